### sv/bbc_pkg.sv
package bbc_pkg;

    localparam int DEPTH  = 4096;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LEN_W  = 13;

    localparam logic [LEN_W-1:0] LEN_RESET    = LEN_W'(DEPTH);
    localparam logic [31:0]      CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0]      CRC_ALL_ONES = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        OP_READ8   = 3'd0,
        OP_WRITE8  = 3'd1,
        OP_READ16  = 3'd2,
        OP_WRITE16 = 3'd3,
        OP_READ32  = 3'd4,
        OP_WRITE32 = 3'd5,
        OP_CRC32   = 3'd6
    } t_op;

    typedef struct packed {
        t_op              operation;
        logic [LEN_W-1:0] offset;
        logic [LEN_W-1:0] range_length;
        logic [31:0]      write_value;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        in_bounds;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic issue;
        logic clear_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic ok;
        logic count_zero;
        logic last_issue;
        logic clear_last;
        logic out_valid;
    } t_dp_sts;

    typedef logic [31:0] t_crc_table [256];

    function automatic t_crc_table build_crc_table();
        t_crc_table  tbl;
        logic [31:0] c;
        for (int n = 0; n < 256; n++) begin
            c = 32'(n);
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            tbl[n] = c;
        end
        return tbl;
    endfunction

    localparam t_crc_table CRC_TABLE = build_crc_table();

endpackage

### sv/bbc_ctrl.sv
module bbc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output bbc_pkg::t_dp_cmd o_cmd,
    input  bbc_pkg::t_dp_sts i_sts
);
    import bbc_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_RUN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_sts.ok || i_sts.count_zero) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!i_sts.out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### sv/bbc_dpath.sv
module bbc_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bbc_pkg::t_in_item              i_in_data,
    input  logic [bbc_pkg::LEN_W-1:0]      i_buffer_length,
    input  logic                           i_out_ready,
    input  bbc_pkg::t_dp_cmd               i_cmd,
    output bbc_pkg::t_dp_sts               o_sts,
    output logic                           o_out_valid,
    output bbc_pkg::t_out_item             o_out_data
);
    import bbc_pkg::*;

    logic [7:0]        mem [DEPTH];

    t_op               r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [LEN_W-1:0]  r_remaining;
    logic [31:0]       r_wdata;
    logic [31:0]       r_acc;
    logic [31:0]       r_crc;
    logic [1:0]        r_lane;
    logic              r_ok;
    logic              r_rd_valid;
    logic [7:0]        r_rdata;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [LEN_W-1:0]  bound;
    logic [LEN_W-1:0]  size;
    logic              size_valid;
    logic [LEN_W:0]    end_pos;
    logic              fits;
    logic              is_write;
    logic              mem_we;
    logic [7:0]        mem_wd;
    logic [31:0]       crc_next;
    t_out_item         result;

    assign bound = (i_buffer_length > LEN_W'(DEPTH)) ? LEN_W'(DEPTH) : i_buffer_length;

    always_comb begin
        size       = '0;
        size_valid = 1'b1;
        case (i_in_data.operation)
            OP_READ8, OP_WRITE8:   size = LEN_W'(1);
            OP_READ16, OP_WRITE16: size = LEN_W'(2);
            OP_READ32, OP_WRITE32: size = LEN_W'(4);
            OP_CRC32:              size = i_in_data.range_length;
            default:               size_valid = 1'b0;
        endcase
    end

    assign end_pos = {1'b0, i_in_data.offset} + {1'b0, size};
    assign fits    = size_valid && (end_pos <= {1'b0, bound});

    assign is_write = (r_op == OP_WRITE8) || (r_op == OP_WRITE16) || (r_op == OP_WRITE32);
    assign mem_we   = i_cmd.clear_step || (i_cmd.issue && is_write);
    assign mem_wd   = i_cmd.clear_step ? 8'h00 : r_wdata[7:0];

    assign crc_next = (r_crc >> 8) ^ CRC_TABLE[r_crc[7:0] ^ r_rdata];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_addr] <= mem_wd;
        end
        r_rdata <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr     <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.issue && !is_write;
            if (i_cmd.start) begin
                r_addr <= i_in_data.offset[ADDR_W-1:0];
            end else if (i_cmd.issue || i_cmd.clear_step) begin
                r_addr <= r_addr + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op        <= i_in_data.operation;
            r_remaining <= size;
            r_wdata     <= i_in_data.write_value;
            r_ok        <= fits;
            r_acc       <= '0;
            r_crc       <= CRC_ALL_ONES;
            r_lane      <= '0;
        end else begin
            if (i_cmd.issue) begin
                r_remaining <= r_remaining - LEN_W'(1);
                r_wdata     <= r_wdata >> 8;
            end
            if (r_rd_valid) begin
                r_acc[8*r_lane +: 8] <= r_rdata;
                r_lane               <= r_lane + 2'd1;
                r_crc                <= crc_next;
            end
        end
    end

    always_comb begin
        result.in_bounds = r_ok;
        result.read_data = '0;
        if (r_ok) begin
            case (r_op)
                OP_READ8, OP_READ16, OP_READ32: result.read_data = r_acc;
                OP_CRC32:                       result.read_data = r_crc ^ CRC_ALL_ONES;
                default:                        result.read_data = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= result;
        end
    end

    assign o_sts.ok         = r_ok;
    assign o_sts.count_zero = (r_remaining == '0);
    assign o_sts.last_issue = (r_remaining == LEN_W'(1));
    assign o_sts.clear_last = (r_addr == ADDR_W'(DEPTH - 1));
    assign o_sts.out_valid  = r_out_valid;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### sv/byte_buffer_access_crc32_top.sv
// An accepted transaction touching n bytes (1, 2 or 4, or range_length for a CRC) is
// checked, then moves its bytes, drains the last read and loads its result; a rejected or
// empty one goes straight from the check to the result. No new transaction is taken until
// its result is loaded, and an unaccepted earlier result delays that load; the single-port
// byte memory moves one byte per cycle. Reset: synchronous, active low; afterwards a
// clearing pass zeroes all 4096 bytes with o_in_ready low, while configuration writes are still taken.
module byte_buffer_access_crc32_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bbc_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bbc_pkg::t_out_item  o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import bbc_pkg::*;

    localparam logic REG_BUFFER_LENGTH = 1'b0;

    logic [LEN_W-1:0] r_buffer_length;
    t_dp_cmd          cmd;
    t_dp_sts          sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_length <= LEN_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_BUFFER_LENGTH)) begin
            r_buffer_length <= pwdata[LEN_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BUFFER_LENGTH) ? {(32 - LEN_W)'(0), r_buffer_length}
                                                    : 32'd0;

    bbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    bbc_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_data       (i_in_data),
        .i_buffer_length (r_buffer_length),
        .i_out_ready     (i_out_ready),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_valid     (o_out_valid),
        .o_out_data      (o_out_data)
    );

endmodule

### sv/bbc_checker.sv
module bbc_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_ready,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  bbc_pkg::t_out_item  o_out_data,
    input  logic                pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output transaction changed while stalled");

    a_oob_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.in_bounds |-> o_out_data.read_data == 32'd0)
        else $error("out-of-bounds transaction returned nonzero data");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while a transaction is in progress");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> !o_out_valid)
        else $error("result appeared in the cycle after acceptance");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("configuration port stalled");

endmodule

bind byte_buffer_access_crc32_top bbc_checker u_bbc_checker (.*);

### tb/byte_buffer_access_crc32_top_test.sv
module byte_buffer_access_crc32_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bbc_pkg::*;

    localparam logic [2:0] OP_UNUSED   = 3'd7;
    localparam logic [2:0] LENGTH_ADDR = 3'd0;
    localparam int         NUM_PHASES  = 10;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [7:0]       shadow_bytes [DEPTH] = '{default: 8'h00};
    logic [LEN_W-1:0] shadow_length = LEN_RESET;

    t_in_item  request_q [$];
    t_out_item expected_q [$];
    t_out_item oldest_result;

    int  mismatches  = 0;
    int  in_gap      = 0;
    int  out_stall   = 0;
    bit  in_idle_on  = 1'b1;
    bit  out_idle_on = 1'b1;

    int  length_plan [NUM_PHASES] = '{4096, 37, 0, 8191, 1, 4097, 300, 4, 2000, 2};
    int  count_plan  [NUM_PHASES] = '{400, 150, 40, 250, 40, 120, 150, 60, 150, 60};

    byte_buffer_access_crc32_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #2 i_clk = ~i_clk;

    task automatic note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("Mismatch: %s", msg);
        end
    endtask

    function automatic int idle_length(bit enabled);
        int roll;
        if (!enabled) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end else if (roll < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_out_item buffer_response(t_in_item req);
        t_out_item   rsp;
        int          lim;
        int          first;
        int          size;
        logic [31:0] crc;
        rsp   = '0;
        lim   = (shadow_length > DEPTH) ? DEPTH : int'(shadow_length);
        first = int'(req.offset);
        case (req.operation)
            OP_READ8, OP_WRITE8: size = 1;
            OP_READ16, OP_WRITE16: size = 2;
            OP_READ32, OP_WRITE32: size = 4;
            OP_CRC32: size = int'(req.range_length);
            default: size = -1;
        endcase
        if (size >= 0 && first + size <= lim) begin
            rsp.in_bounds = 1'b1;
            case (req.operation)
                OP_WRITE8, OP_WRITE16, OP_WRITE32: begin
                    for (int i = 0; i < size; i++) begin
                        shadow_bytes[first + i] = req.write_value[8*i +: 8];
                    end
                end
                OP_CRC32: begin
                    crc = CRC_ALL_ONES;
                    for (int i = 0; i < size; i++) begin
                        crc = crc ^ {24'h0, shadow_bytes[first + i]};
                        for (int k = 0; k < 8; k++) begin
                            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
                        end
                    end
                    rsp.read_data = crc ^ CRC_ALL_ONES;
                end
                default: begin
                    for (int i = 0; i < size; i++) begin
                        rsp.read_data[8*i +: 8] = shadow_bytes[first + i];
                    end
                end
            endcase
        end
        return rsp;
    endfunction

    function automatic t_in_item request(t_op op, int off, int rlen, logic [31:0] value);
        t_in_item req;
        req.operation    = op;
        req.offset       = LEN_W'(off);
        req.range_length = LEN_W'(rlen);
        req.write_value  = value;
        return req;
    endfunction

    function automatic t_in_item random_request();
        t_in_item req;
        int       lim;
        int       span;
        int       hi;
        int       off;
        int       roll;
        lim = (shadow_length > DEPTH) ? DEPTH : int'(shadow_length);
        req.write_value  = $urandom();
        req.range_length = LEN_W'($urandom_range(0, 8191));
        if ($urandom_range(0, 99) < 12) begin
            req.operation = t_op'($urandom_range(0, 7));
            req.offset    = LEN_W'($urandom_range(0, 8191));
            if ($urandom_range(0, 1) == 0) begin
                req.range_length = LEN_W'($urandom_range(0, 8));
            end
            return req;
        end
        req.operation = t_op'($urandom_range(0, 6));
        case (req.operation)
            OP_READ8, OP_WRITE8: span = 1;
            OP_READ16, OP_WRITE16: span = 2;
            OP_READ32, OP_WRITE32: span = 4;
            default: begin
                roll = $urandom_range(0, 99);
                if (roll < 85) begin
                    span = $urandom_range(0, 16);
                end else if (roll < 97) begin
                    span = $urandom_range(0, 256);
                end else begin
                    span = $urandom_range(0, lim);
                end
                if (span > lim) begin
                    span = lim;
                end
                req.range_length = LEN_W'(span);
            end
        endcase
        hi   = lim - span;
        roll = $urandom_range(0, 99);
        if (hi < 0) begin
            off = $urandom_range(0, lim);
        end else if (roll < 5) begin
            off = hi + 1;
        end else if (roll < 50) begin
            off = $urandom_range(0, (hi < 47) ? hi : 47);
        end else if (roll < 75) begin
            off = hi - $urandom_range(0, (hi < 7) ? hi : 7);
        end else begin
            off = $urandom_range(0, hi);
        end
        req.offset = LEN_W'(off);
        return req;
    endfunction

    task automatic set_length(int len);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LENGTH_ADDR;
        pwdata  <= 32'(len);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        shadow_length = LEN_W'(len);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== 32'(shadow_length)) begin
            note_mismatch($sformatf("buffer_length readback: expected %h, got %h",
                                    32'(shadow_length), prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (request_q.size() != 0 || i_in_valid || expected_q.size() != 0);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap     <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_q.push_back(buffer_response(i_in_data));
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    i_in_valid <= 1'b0;
                    in_gap     <= in_gap - 1;
                end else if (request_q.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= request_q.pop_front();
                    in_gap     <= idle_length(in_idle_on);
                end else begin
                    i_in_valid <= 1'b0;
                end
                if ($urandom_range(0, 99) == 0) begin
                    in_idle_on <= !in_idle_on;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_stall   <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    note_mismatch($sformatf("result %h arrived with none expected",
                                            o_out_data));
                end else begin
                    oldest_result = expected_q.pop_front();
                    if (o_out_data.read_data !== oldest_result.read_data) begin
                        note_mismatch($sformatf("read_data: expected %h, got %h",
                                                oldest_result.read_data,
                                                o_out_data.read_data));
                    end
                    if (o_out_data.in_bounds !== oldest_result.in_bounds) begin
                        note_mismatch($sformatf("in_bounds: expected %b, got %b",
                                                oldest_result.in_bounds,
                                                o_out_data.in_bounds));
                    end
                end
            end
            if (out_stall > 0) begin
                i_out_ready <= 1'b0;
                out_stall   <= out_stall - 1;
            end else begin
                i_out_ready <= 1'b1;
                out_stall   <= idle_length(out_idle_on);
            end
            if ($urandom_range(0, 99) == 0) begin
                out_idle_on <= !out_idle_on;
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The reset length is in effect here, and the store is cleared before the first request is taken.
        request_q.push_back(request(OP_READ32, 0, 0, 32'h0));
        request_q.push_back(request(OP_WRITE32, 0, 0, 32'hFFFF_FFFF));
        request_q.push_back(request(OP_READ32, 0, 0, 32'h0));
        request_q.push_back(request(OP_WRITE8, 4095, 0, 32'h1234_56A5));
        request_q.push_back(request(OP_READ8, 4095, 0, 32'h0));
        request_q.push_back(request(OP_READ16, 4095, 0, 32'h0));
        request_q.push_back(request(OP_WRITE16, 4094, 0, 32'hFFFF_BEEF));
        request_q.push_back(request(OP_READ16, 4094, 0, 32'h0));
        request_q.push_back(request(OP_READ32, 4092, 0, 32'h0));
        request_q.push_back(request(OP_WRITE32, 4093, 0, 32'hDEAD_BEEF));
        request_q.push_back(request(OP_WRITE32, 100, 0, 32'h3433_3231));
        request_q.push_back(request(OP_WRITE32, 104, 0, 32'h3837_3635));
        request_q.push_back(request(OP_WRITE8, 108, 0, 32'hFFFF_FF39));
        request_q.push_back(request(OP_CRC32, 100, 9, 32'h0));
        request_q.push_back(request(OP_CRC32, 4096, 0, 32'h0));
        request_q.push_back(request(OP_CRC32, 0, 0, 32'h0));
        request_q.push_back(request(OP_CRC32, 4097, 0, 32'h0));
        request_q.push_back(request(OP_CRC32, 0, 4096, 32'h0));
        request_q.push_back(request(OP_CRC32, 8191, 8191, 32'h0));
        request_q.push_back(request(t_op'(OP_UNUSED), 0, 0, 32'hFFFF_FFFF));
        request_q.push_back(request(OP_READ8, 8191, 0, 32'h0));
        request_q.push_back(request(OP_WRITE8, 4096, 0, 32'h0000_0077));
        request_q.push_back(request(OP_READ32, 100, 0, 32'h0));
        request_q.push_back(request(OP_WRITE16, 0, 0, 32'h0000_0000));
        request_q.push_back(request(OP_READ8, 1, 0, 32'h0));
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_length(length_plan[p]);
            for (int n = 0; n < count_plan[p]; n++) begin
                request_q.push_back(random_request());
            end
            wait_drained();
        end

        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

### byte_buffer_access_crc32_top.f
sv/bbc_pkg.sv
sv/bbc_ctrl.sv
sv/bbc_dpath.sv
sv/byte_buffer_access_crc32_top.sv
sv/bbc_checker.sv
tb/byte_buffer_access_crc32_top_test.sv
